@@ design/tked_pkg.sv @@
// Package with the shared types, key codes and the lookup function of the key decoder.
`timescale 1ns / 1ps
package tked_pkg;

  localparam int unsigned KeyW   = 10;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 16;
  localparam int unsigned AccW   = 8;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_ESC  = 2'd1,
    MODE_SS3  = 2'd2,
    MODE_CSI  = 2'd3
  } mode_e;

  localparam logic [KeyW-1:0] KEY_ESC   = 10'd27;
  localparam logic [KeyW-1:0] KEY_UP    = 10'd256;
  localparam logic [KeyW-1:0] KEY_DOWN  = 10'd257;
  localparam logic [KeyW-1:0] KEY_LEFT  = 10'd258;
  localparam logic [KeyW-1:0] KEY_RIGHT = 10'd259;
  localparam logic [KeyW-1:0] KEY_HOME  = 10'd260;
  localparam logic [KeyW-1:0] KEY_END   = 10'd261;
  localparam logic [KeyW-1:0] KEY_PGUP  = 10'd262;
  localparam logic [KeyW-1:0] KEY_PGDN  = 10'd263;
  localparam logic [KeyW-1:0] KEY_INS   = 10'd264;
  localparam logic [KeyW-1:0] KEY_DEL   = 10'd265;
  localparam logic [KeyW-1:0] KEY_F1    = 10'd266;
  localparam logic [KeyW-1:0] KEY_ALT   = 10'd512;

  localparam logic [ByteW-1:0] CH_ESC   = 8'd27;
  localparam logic [ByteW-1:0] CH_O     = 8'h4F;
  localparam logic [ByteW-1:0] CH_LBRK  = 8'h5B;
  localparam logic [ByteW-1:0] CH_SEMI  = 8'h3B;
  localparam logic [ByteW-1:0] CH_TILDE = 8'h7E;
  localparam logic [ByteW-1:0] CH_0     = 8'h30;
  localparam logic [ByteW-1:0] CH_9     = 8'h39;
  localparam logic [ByteW-1:0] CH_P     = 8'h50;
  localparam logic [ByteW-1:0] CH_S     = 8'h53;
  localparam logic [ByteW-1:0] CH_UA    = 8'h41;
  localparam logic [ByteW-1:0] CH_UZ    = 8'h5A;
  localparam logic [ByteW-1:0] CH_A     = 8'h41;
  localparam logic [ByteW-1:0] CH_B     = 8'h42;
  localparam logic [ByteW-1:0] CH_C     = 8'h43;
  localparam logic [ByteW-1:0] CH_D     = 8'h44;
  localparam logic [ByteW-1:0] CH_F     = 8'h46;
  localparam logic [ByteW-1:0] CH_H     = 8'h48;

  localparam logic [CountW-1:0] EscWaitReset = 16'd200;

  typedef struct packed {
    mode_e             mode;
    logic [AccW-1:0]   accum;
    logic              digit_seen;
    logic [CountW-1:0] idle_count;
  } parse_state_t;

  typedef struct packed {
    parse_state_t    next;
    logic            emit;
    logic [KeyW-1:0] key;
  } step_result_t;

  // Key selected by a tilde final for the given parameter.
  function automatic logic [KeyW-1:0] tilde_key(input logic [AccW-1:0] n);
    logic [KeyW-1:0] k;
    unique case (n)
      8'd1:    k = KEY_HOME;
      8'd2:    k = KEY_INS;
      8'd3:    k = KEY_DEL;
      8'd4:    k = KEY_END;
      8'd5:    k = KEY_PGUP;
      8'd6:    k = KEY_PGDN;
      8'd11:   k = KEY_F1;
      8'd12:   k = KEY_F1 + 10'd1;
      8'd13:   k = KEY_F1 + 10'd2;
      8'd14:   k = KEY_F1 + 10'd3;
      8'd15:   k = KEY_F1 + 10'd4;
      8'd17:   k = KEY_F1 + 10'd5;
      8'd18:   k = KEY_F1 + 10'd6;
      8'd19:   k = KEY_F1 + 10'd7;
      8'd20:   k = KEY_F1 + 10'd8;
      8'd21:   k = KEY_F1 + 10'd9;
      8'd23:   k = KEY_F1 + 10'd10;
      8'd24:   k = KEY_F1 + 10'd11;
      default: k = KEY_ESC;
    endcase
    return k;
  endfunction

endpackage

@@ design/tked_step.sv @@
// Combinational decode of one byte or idle tick against the current parser state.
`timescale 1ns / 1ps
module tked_step (
  input  tked_pkg::parse_state_t               state_i,
  input  logic [tked_pkg::CountW-1:0]          esc_wait_i,
  input  logic                                 req_type_i,
  input  logic [tked_pkg::ByteW-1:0]           byte_value_i,
  output tked_pkg::step_result_t               result_o
);
  import tked_pkg::*;

  logic [CountW:0]   tick_count;
  logic              timeout;
  logic [11:0]       acc_times_ten;
  logic [AccW-1:0]   acc_sat;
  logic [ByteW-1:0]  lowered;
  parse_state_t      idle_state;

  assign tick_count    = {1'b0, state_i.idle_count} + {{CountW{1'b0}}, 1'b1};
  assign timeout       = tick_count > {1'b0, esc_wait_i};
  assign acc_times_ten = {1'b0, state_i.accum, 3'b000} + {3'b000, state_i.accum, 1'b0}
                       + {8'd0, byte_value_i[3:0]};
  assign acc_sat       = (acc_times_ten > 12'd255) ? 8'd255 : acc_times_ten[AccW-1:0];
  // Upper-case letters are folded to lower case for Alt keys.
  assign lowered       = ((byte_value_i >= CH_UA) && (byte_value_i <= CH_UZ))
                       ? (byte_value_i + 8'd32) : byte_value_i;

  always_comb begin
    idle_state            = '0;
    idle_state.mode       = MODE_IDLE;
    result_o.next         = state_i;
    result_o.emit         = 1'b0;
    result_o.key          = KEY_ESC;
    if (req_type_i) begin
      if (state_i.mode != MODE_IDLE) begin
        if (timeout) begin
          result_o.next = idle_state;
          result_o.emit = 1'b1;
        end else begin
          result_o.next.idle_count = tick_count[CountW-1:0];
        end
      end
    end else begin
      result_o.next.idle_count = '0;
      unique case (state_i.mode)
        MODE_IDLE: begin
          if (byte_value_i == CH_ESC) begin
            result_o.next.mode = MODE_ESC;
          end else begin
            result_o.emit = 1'b1;
            result_o.key  = {2'b00, byte_value_i};
          end
        end
        MODE_ESC: begin
          if (byte_value_i == CH_O) begin
            result_o.next.mode = MODE_SS3;
          end else if (byte_value_i == CH_LBRK) begin
            result_o.next.mode       = MODE_CSI;
            result_o.next.accum      = '0;
            result_o.next.digit_seen = 1'b0;
          end else begin
            result_o.next = idle_state;
            result_o.emit = 1'b1;
            result_o.key  = KEY_ALT | {2'b00, lowered};
          end
        end
        MODE_SS3: begin
          result_o.next = idle_state;
          result_o.emit = 1'b1;
          if ((byte_value_i >= CH_P) && (byte_value_i <= CH_S)) begin
            result_o.key = KEY_F1 + {8'd0, byte_value_i[1:0]};
          end
        end
        MODE_CSI: begin
          if ((byte_value_i >= CH_0) && (byte_value_i <= CH_9)) begin
            result_o.next.accum      = acc_sat;
            result_o.next.digit_seen = 1'b1;
          end else if (byte_value_i == CH_SEMI) begin
            result_o.next.accum = '0;
          end else begin
            result_o.next = idle_state;
            result_o.emit = 1'b1;
            case (byte_value_i)
              CH_A:     result_o.key = KEY_UP;
              CH_B:     result_o.key = KEY_DOWN;
              CH_C:     result_o.key = KEY_RIGHT;
              CH_D:     result_o.key = KEY_LEFT;
              CH_H:     result_o.key = KEY_HOME;
              CH_F:     result_o.key = KEY_END;
              CH_TILDE: result_o.key = state_i.digit_seen ? tilde_key(state_i.accum)
                                                          : KEY_ESC;
              default:  result_o.key = KEY_ESC;
            endcase
          end
        end
        default: result_o.next = idle_state;
      endcase
    end
  end

endmodule

@@ design/tked_out_buf.sv @@
// Two-entry output register with skid stage for the decoded key codes.
`timescale 1ns / 1ps
module tked_out_buf (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  logic [tked_pkg::KeyW-1:0]   push_key_i,
  output logic                        full_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [tked_pkg::KeyW-1:0]   key_code_o
);
  import tked_pkg::*;

  logic            main_valid_q, main_valid_d;
  logic            skid_valid_q, skid_valid_d;
  logic [KeyW-1:0] main_key_q, main_key_d;
  logic [KeyW-1:0] skid_key_q, skid_key_d;
  logic            pop;

  assign pop = main_valid_q && out_ready_i;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_key_d   = main_key_q;
    skid_key_d   = skid_key_q;
    if (skid_valid_q) begin
      if (pop) begin
        main_key_d   = skid_key_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!main_valid_q || pop) begin
        main_key_d   = push_key_i;
        main_valid_d = 1'b1;
      end else begin
        skid_key_d   = push_key_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      main_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_key_q <= main_key_d;
    skid_key_q <= skid_key_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign key_code_o  = main_key_q;

endmodule

@@ design/terminal_key_escape_decoder_top.sv @@
// Top level of the terminal key escape decoder: parser state, config register and output buffer.
`timescale 1ns / 1ps
// While input ready is high, the decoder takes one keyboard byte or idle tick per cycle and
// turns escape sequences into key codes: plain bytes pass through, ESC O P..S gives F1-F4,
// CSI sequences with a decimal parameter give cursor, editing and function keys, and any
// other byte after ESC gives an Alt key (512 plus the byte, letters lowered). Each transfer
// on the input channel is decoded by one combinational step between the parser state
// registers and the output register, so the block sustains one input transfer per clock
// while input ready is high. Items that finish a key produce exactly one output transfer,
// the rest produce none. The output side has a two-entry buffer (output register plus skid
// stage), so the input keeps accepting while a finished key waits to be taken; input ready
// drops only while both entries are full. A sequence that sees more idle ticks than the
// esc_wait register allows is dropped and reported as a plain Escape (27). The esc_wait
// register resets to 200 and is written through its own channel, which is always ready; it
// should only be written while no sequence is in progress.
module terminal_key_escape_decoder_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          req_type_i,
  input  logic [tked_pkg::ByteW-1:0]    byte_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tked_pkg::KeyW-1:0]     key_code_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tked_pkg::CountW-1:0]   cfg_data_i
);
  import tked_pkg::*;

  parse_state_t      state_q;
  parse_state_t      state_d;
  step_result_t      step;
  logic [CountW-1:0] esc_wait_q;
  logic              in_xfer;
  logic              buf_full;

  // The configuration write always completes in the cycle it is offered.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_wait_q <= EscWaitReset;
    end else if (cfg_valid_i) begin
      esc_wait_q <= cfg_data_i;
    end
  end

  tked_step u_step (
    .state_i      (state_q),
    .esc_wait_i   (esc_wait_q),
    .req_type_i   (req_type_i),
    .byte_value_i (byte_value_i),
    .result_o     (step)
  );

  assign in_ready_o = !buf_full;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign state_d    = in_xfer ? step.next : state_q;

  // Parser state only moves on an accepted input transfer. The all-zero state is idle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  tked_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_xfer && step.emit),
    .push_key_i  (step.key),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .key_code_o  (key_code_o)
  );

  // Outside a CSI sequence the parameter and digit flag stay cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.mode != MODE_CSI) |-> (state_q.accum == '0) && !state_q.digit_seen)
    else $error("CSI parameter left over outside a CSI sequence");

  // No idle ticks are counted outside a sequence.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.mode == MODE_IDLE) |-> (state_q.idle_count == '0))
    else $error("idle count nonzero outside a sequence");

  // A key decoded into an empty buffer shows up on the output in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && step.emit && !out_valid_o) |=>
      out_valid_o && (key_code_o == $past(step.key)))
    else $error("decoded key lost on its way to the output");

  // A timed-out sequence returns the parser to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && req_type_i && step.emit) |=> (state_q.mode == MODE_IDLE))
    else $error("parser not idle after sequence timeout");

endmodule

@@ sim/tked_key_checker.sv @@
// Checker that predicts the key codes of the escape decoder and compares them with its output.
`timescale 1ns / 1ps
module tked_key_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic                        req_type_i,
  input  logic [tked_pkg::ByteW-1:0]  byte_value_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic [tked_pkg::KeyW-1:0]   key_code_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [tked_pkg::CountW-1:0] cfg_data_i,
  output int                          fail_count_o,
  output int                          pending_keys_o
);
  import tked_pkg::*;

  localparam logic [ByteW-1:0] LowerCaseOffset = 8'd32;

  // Private copy of the decoder state and of its timeout register.
  mode_e             mode;
  logic [AccW-1:0]   param;
  logic              have_digit;
  logic [CountW-1:0] idle_ticks;
  logic [CountW-1:0] esc_wait;

  logic [KeyW-1:0] expected_keys[$];
  int              mismatches;

  function automatic void clear_parser();
    mode       = MODE_IDLE;
    param      = '0;
    have_digit = 1'b0;
    idle_ticks = '0;
  endfunction

  function automatic logic [KeyW-1:0] tilde_code(input logic [AccW-1:0] n);
    logic [KeyW-1:0] k;
    k = KEY_ESC;
    case (n)
      8'd1: k = KEY_HOME;
      8'd2: k = KEY_INS;
      8'd3: k = KEY_DEL;
      8'd4: k = KEY_END;
      8'd5: k = KEY_PGUP;
      8'd6: k = KEY_PGDN;
      default: begin
        // Function keys skip 16 and 22 in their parameter numbering.
        if (n >= 8'd11 && n <= 8'd15) k = KEY_F1 + {2'b00, n - 8'd11};
        else if (n >= 8'd17 && n <= 8'd21) k = KEY_F1 + {2'b00, n - 8'd12};
        else if (n >= 8'd23 && n <= 8'd24) k = KEY_F1 + {2'b00, n - 8'd13};
      end
    endcase
    return k;
  endfunction

  function automatic logic [KeyW-1:0] csi_code(input logic [ByteW-1:0] ch);
    logic [KeyW-1:0] k;
    k = KEY_ESC;
    if (ch == CH_A) k = KEY_UP;
    else if (ch == CH_B) k = KEY_DOWN;
    else if (ch == CH_C) k = KEY_RIGHT;
    else if (ch == CH_D) k = KEY_LEFT;
    else if (ch == CH_H) k = KEY_HOME;
    else if (ch == CH_F) k = KEY_END;
    else if (ch == CH_TILDE && have_digit) k = tilde_code(param);
    return k;
  endfunction

  // Advances the private state by one byte or tick; returns 1 when a key is finished.
  function automatic logic decode_step(input logic tick, input logic [ByteW-1:0] ch,
                                       output logic [KeyW-1:0] key);
    logic [CountW:0]   next_idle;
    logic [11:0]       acc_next;
    logic [ByteW-1:0]  lowered;
    key = KEY_ESC;
    if (tick) begin
      if (mode == MODE_IDLE) return 1'b0;
      next_idle = {1'b0, idle_ticks} + {{CountW{1'b0}}, 1'b1};
      if (next_idle > {1'b0, esc_wait}) begin
        clear_parser();
        return 1'b1;
      end
      idle_ticks = next_idle[CountW-1:0];
      return 1'b0;
    end
    idle_ticks = '0;
    case (mode)
      MODE_IDLE: begin
        if (ch == CH_ESC) begin
          mode = MODE_ESC;
          return 1'b0;
        end
        key = {2'b00, ch};
      end
      MODE_ESC: begin
        if (ch == CH_O) begin
          mode = MODE_SS3;
          return 1'b0;
        end
        if (ch == CH_LBRK) begin
          mode       = MODE_CSI;
          param      = '0;
          have_digit = 1'b0;
          return 1'b0;
        end
        lowered = (ch >= CH_UA && ch <= CH_UZ) ? ch + LowerCaseOffset : ch;
        key = KEY_ALT + {2'b00, lowered};
      end
      MODE_SS3: begin
        if (ch >= CH_P && ch <= CH_S) key = KEY_F1 + {2'b00, ch - CH_P};
      end
      default: begin
        if (ch >= CH_0 && ch <= CH_9) begin
          acc_next   = 12'(param) * 12'd10 + 12'(ch - CH_0);
          param      = (acc_next > 12'd255) ? 8'd255 : acc_next[AccW-1:0];
          have_digit = 1'b1;
          return 1'b0;
        end
        if (ch == CH_SEMI) begin
          param = '0;
          return 1'b0;
        end
        key = csi_code(ch);
      end
    endcase
    clear_parser();
    return 1'b1;
  endfunction

  always @(posedge clk_i) begin : watch
    logic [KeyW-1:0] predicted;
    logic [KeyW-1:0] oldest;
    if (!rst_ni) begin
      clear_parser();
      esc_wait = EscWaitReset;
      expected_keys.delete();
      mismatches = 0;
    end else begin
      // Results are checked before the input of the same edge is predicted;
      // a key can never leave in the cycle its input arrives.
      if (out_valid_i && out_ready_i) begin
        if (expected_keys.size() == 0) begin
          $display("%0t: key %0d arrived with nothing expected", $time, key_code_i);
          mismatches++;
        end else begin
          oldest = expected_keys.pop_front();
          if (key_code_i !== oldest) begin
            $display("%0t: key mismatch, expected %0d, actual %0d",
                     $time, oldest, key_code_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (decode_step(req_type_i, byte_value_i, predicted))
          expected_keys.push_back(predicted);
      end
      // A register write takes effect for inputs after this edge.
      if (cfg_valid_i && cfg_ready_i) esc_wait = cfg_data_i;
    end
    fail_count_o   <= mismatches;
    pending_keys_o <= expected_keys.size();
  end

endmodule

@@ sim/tb_terminal_key_escape_decoder_top.sv @@
// Testbench top for the terminal key escape decoder: stimulus, handshakes and the verdict.
`timescale 1ns / 1ps
// The top only produces traffic. It feeds bytes and idle ticks into the decoder, writes the
// esc_wait register between phases, and randomly stalls the key output. All prediction and
// comparison happens in tked_key_checker, which reports how many keys are still outstanding
// and how many mismatches it has seen.
module tb_terminal_key_escape_decoder_top;
  import tked_pkg::*;

  // About a thousand items, each with a random input gap and a wait behind random
  // output stalls, stay well under this limit.
  localparam int CycleLimit = 200000;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic              req_type_i;
  logic [ByteW-1:0]  byte_value_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [KeyW-1:0]   key_code_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [CountW-1:0] cfg_data_i;

  int fail_count;
  int keys_pending;
  int cycles;
  int unsigned items_sent;
  bit idling_on;

  // CSI parameters that select a real key with a tilde final.
  int unsigned tilde_params [0:17] = '{1, 2, 3, 4, 5, 6, 11, 12, 13, 14, 15,
                                       17, 18, 19, 20, 21, 23, 24};

  terminal_key_escape_decoder_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .byte_value_i(byte_value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .key_code_o  (key_code_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  tked_key_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .req_type_i    (req_type_i),
    .byte_value_i  (byte_value_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .key_code_i    (key_code_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .pending_keys_o(keys_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake or a key that never comes ends the run here.
  initial begin
    cycles = 0;
    while (cycles <= CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("terminal_key_escape_decoder_top verification failed");
    $finish;
  end

  // The key receiver stalls in random bursts while idling is enabled, and is
  // always ready otherwise.
  initial begin
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (idling_on && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // Presents one item and returns at the edge of its transfer. A random gap
  // may come first; valid is only lowered for such a gap, so back-to-back
  // items keep valid high across the transfer edge.
  task automatic send_item(input logic tick, input logic [ByteW-1:0] value);
    if (idling_on && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= tick;
    byte_value_i <= value;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_byte(input logic [ByteW-1:0] value);
    send_item(1'b0, value);
  endtask

  // The byte lane carries random junk on ticks, since the decoder must ignore it.
  task automatic send_tick();
    send_item(1'b1, ByteW'($urandom_range(0, 255)));
  endtask

  // Stops input and waits until every predicted key has been taken, then
  // lets the output buffer settle.
  task automatic drain_keys();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (keys_pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // An 'A' ends whatever sequence is open (or is a plain key if none is), so
  // the decoder is back outside any sequence before the register changes.
  task automatic close_and_drain();
    send_byte(CH_A);
    drain_keys();
  endtask

  task automatic write_esc_wait(input logic [CountW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Now and then a run of idle ticks lands inside a sequence; with a small
  // esc_wait this is what makes timeouts happen.
  task automatic maybe_ticks();
    if ($urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 12)) send_tick();
  endtask

  // Sends a decimal parameter, sometimes with a leading zero.
  task automatic send_number(input int unsigned v);
    if ($urandom_range(0, 7) == 0) send_byte(CH_0);
    if (v >= 100) send_byte(CH_0 + ByteW'(v / 100));
    if (v >= 10) send_byte(CH_0 + ByteW'((v / 10) % 10));
    send_byte(CH_0 + ByteW'(v % 10));
  endtask

  task automatic send_csi_sequence();
    int unsigned groups;
    int unsigned v;
    send_byte(CH_ESC);
    maybe_ticks();
    send_byte(CH_LBRK);
    case ($urandom_range(0, 4))
      0:       groups = 0;
      4:       groups = 2;
      default: groups = 1;
    endcase
    for (int g = 0; g < groups; g++) begin
      if (g > 0) send_byte(CH_SEMI);
      maybe_ticks();
      // Mostly parameters that name a key, otherwise small random ones or ones
      // up to 999 that can saturate the accumulator. Some groups stay empty.
      case ($urandom_range(0, 3))
        0, 1:    v = tilde_params[$urandom_range(0, 17)];
        2:       v = $urandom_range(0, 30);
        default: v = $urandom_range(0, 999);
      endcase
      if ($urandom_range(0, 4) != 0) send_number(v);
    end
    maybe_ticks();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: send_byte(CH_TILDE);
      6, 7, 8: begin
        case ($urandom_range(0, 5))
          0:       send_byte(CH_A);
          1:       send_byte(CH_B);
          2:       send_byte(CH_C);
          3:       send_byte(CH_D);
          4:       send_byte(CH_H);
          default: send_byte(CH_F);
        endcase
      end
      // A random final is usually unknown, but can also be a digit or a
      // semicolon that keeps the sequence open.
      default: send_byte(ByteW'($urandom_range(0, 255)));
    endcase
  endtask

  // One unit of random traffic: mostly well-formed sequences with random
  // content, with plain bytes, stray ticks and broken sequences mixed in.
  task automatic send_random_sequence();
    case ($urandom_range(0, 9))
      0, 1: send_byte(ByteW'($urandom_range(0, 255)));
      2:    send_tick();
      3: begin
        send_byte(CH_ESC);
        maybe_ticks();
        send_byte(CH_O);
        maybe_ticks();
        if ($urandom_range(0, 3) == 0) send_byte(ByteW'($urandom_range(0, 255)));
        else send_byte(CH_P + ByteW'($urandom_range(0, 3)));
      end
      4: begin
        // Alt keys; the random byte may itself be an Escape, 'O' or '['.
        send_byte(CH_ESC);
        maybe_ticks();
        send_byte(ByteW'($urandom_range(0, 255)));
      end
      default: send_csi_sequence();
    endcase
  endtask

  // Random traffic until roughly n more items have been transferred. Idling
  // is switched on and off in stretches unless this is the quiet tail.
  task automatic random_phase(input int unsigned n, input bit allow_idling);
    int unsigned stop_at;
    stop_at   = items_sent + n;
    idling_on = allow_idling;
    while (items_sent < stop_at) begin
      if (allow_idling && $urandom_range(0, 15) == 0)
        idling_on = ($urandom_range(0, 3) != 0);
      send_random_sequence();
    end
  endtask

  initial begin
    in_valid_i   <= 1'b0;
    req_type_i   <= 1'b0;
    byte_value_i <= '0;
    cfg_valid_i  <= 1'b0;
    cfg_data_i   <= '0;
    rst_ni       <= 1'b0;
    items_sent   = 0;
    idling_on    = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed checks with esc_wait at its reset value.
    idling_on = 1'b1;
    send_byte(8'h00);              // lowest plain byte
    send_byte(8'hFF);              // highest plain byte
    send_tick();                   // tick outside a sequence does nothing
    send_byte(CH_ESC);             // ESC O P is F1
    send_byte(CH_O);
    send_byte(CH_P);
    send_byte(CH_ESC);             // ESC O S is F4, with a tick in between
    send_byte(CH_O);
    send_tick();
    send_byte(CH_S);
    send_byte(CH_ESC);             // ESC O followed by anything else is Escape
    send_byte(CH_O);
    send_byte(CH_UZ);
    send_byte(CH_ESC);             // cursor up
    send_byte(CH_LBRK);
    send_byte(CH_A);
    send_byte(CH_ESC);             // parameter 24 with tilde is F12
    send_byte(CH_LBRK);
    send_number(24);
    send_byte(CH_TILDE);
    send_byte(CH_ESC);             // parameter 999 saturates and names nothing
    send_byte(CH_LBRK);
    send_number(999);
    send_byte(CH_TILDE);
    send_byte(CH_ESC);             // the semicolon restarts the number: PgUp
    send_byte(CH_LBRK);
    send_number(1);
    send_byte(CH_SEMI);
    send_number(5);
    send_byte(CH_TILDE);
    send_byte(CH_ESC);             // tilde with no digit at all
    send_byte(CH_LBRK);
    send_byte(CH_TILDE);
    send_byte(CH_ESC);             // semicolon only: a digit was never seen
    send_byte(CH_LBRK);
    send_byte(CH_SEMI);
    send_byte(CH_TILDE);
    send_byte(CH_ESC);             // unknown final
    send_byte(CH_LBRK);
    send_byte(8'h78);
    send_byte(CH_ESC);             // Escape twice is Alt-Escape
    send_byte(CH_ESC);
    send_byte(CH_ESC);             // Alt with an upper-case letter is lowered
    send_byte(CH_UZ);

    // Zero tolerance: the first tick inside any sequence times it out.
    close_and_drain();
    write_esc_wait(16'd0);
    send_byte(CH_ESC);
    send_tick();
    send_byte(CH_ESC);
    send_byte(CH_LBRK);
    send_byte(CH_0 + 8'd1);
    send_tick();
    random_phase(70, 1'b1);

    // One tick is tolerated, the second times out; a byte resets the count.
    close_and_drain();
    write_esc_wait(16'd1);
    send_byte(CH_ESC);
    send_tick();
    send_tick();
    send_byte(CH_ESC);
    send_tick();
    send_byte(CH_LBRK);
    send_tick();
    send_byte(CH_B);
    random_phase(70, 1'b1);

    // A timeout above eight bits: 257 ticks are still tolerated, the 258th is not.
    // The tick runs go without gaps to keep the run short.
    close_and_drain();
    write_esc_wait(16'd257);
    idling_on = 1'b0;
    send_byte(CH_ESC);
    send_byte(CH_LBRK);
    repeat (257) send_tick();
    send_byte(CH_A);
    send_byte(CH_ESC);
    repeat (258) send_tick();
    random_phase(70, 1'b1);

    close_and_drain();
    write_esc_wait(CountW'($urandom_range(2, 15)));
    random_phase(100, 1'b1);

    close_and_drain();
    write_esc_wait(CountW'($urandom_range(0, 65535)));
    random_phase(60, 1'b1);

    // Final stretch at full rate on both sides.
    close_and_drain();
    write_esc_wait(16'd3);
    random_phase(80, 1'b0);

    drain_keys();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("terminal_key_escape_decoder_top verification clean");
    end else begin
      $display("terminal_key_escape_decoder_top verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/tked_pkg.sv
design/tked_step.sv
design/tked_out_buf.sv
design/terminal_key_escape_decoder_top.sv
sim/tked_key_checker.sv
sim/tb_terminal_key_escape_decoder_top.sv
